### rtl/tfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_pkg
// Shared types, constants and channel widening helpers for the texel format
// expander.
// ----------------------------------------------------------------------------
package tfe_pkg;

  localparam int unsigned FormatW   = 5;
  localparam int unsigned TexelW    = 32;
  localparam int unsigned ColorW    = 32;
  localparam int unsigned PalDepth  = 256;
  localparam int unsigned PalIndexW = $clog2(PalDepth);

  typedef enum logic [FormatW-1:0] {
    FMT_A8       = 5'd0,
    FMT_Y8       = 5'd1,
    FMT_AY8      = 5'd2,
    FMT_A8Y8     = 5'd3,
    FMT_R5G6B5   = 5'd6,
    FMT_A1R5G5B5 = 5'd8,
    FMT_A4R4G4B4 = 5'd9,
    FMT_X8R8G8B8 = 5'd10,
    FMT_A8R8G8B8 = 5'd11,
    FMT_P8       = 5'd17
  } fmt_e;

  typedef enum logic {
    KIND_CONVERT   = 1'b0,
    KIND_PAL_WRITE = 1'b1
  } kind_e;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

endpackage

### rtl/tfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tfe_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_expand
// Combinational expansion of one raw texel to an A8R8G8B8 color.
// ----------------------------------------------------------------------------
module tfe_expand
  import tfe_pkg::*;
(
  input  logic [FormatW-1:0] format_i,
  input  logic [TexelW-1:0]  texel_i,
  input  logic [ColorW-1:0]  pal_data_i,
  output logic [ColorW-1:0]  color_o,
  output logic               known_o
);

  logic [7:0]  b;
  logic [15:0] p;

  assign b = texel_i[7:0];
  assign p = texel_i[15:0];

  always_comb begin
    known_o = 1'b1;
    unique case (fmt_e'(format_i))
      FMT_A8:       color_o = {b, 24'h000000};
      FMT_Y8:       color_o = {8'hFF, b, b, b};
      FMT_AY8:      color_o = {b, b, b, b};
      FMT_A8Y8:     color_o = {p[15:8], b, b, b};
      FMT_R5G6B5:   color_o = {8'hFF, widen5(p[15:11]), widen6(p[10:5]), widen5(p[4:0])};
      FMT_A1R5G5B5: color_o = {{8{p[15]}}, widen5(p[14:10]), widen5(p[9:5]),
                               widen5(p[4:0])};
      FMT_A4R4G4B4: color_o = {widen4(p[15:12]), widen4(p[11:8]), widen4(p[7:4]),
                               widen4(p[3:0])};
      FMT_X8R8G8B8,
      FMT_A8R8G8B8: color_o = texel_i;
      FMT_P8:       color_o = pal_data_i;
      default: begin
        color_o = '0;
        known_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/texel_format_expand_argb8888.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_format_expand_argb8888
// Texel format expander: raw texel plus format code in, A8R8G8B8 color out.
// ----------------------------------------------------------------------------
// The block takes one word per clock while not held by a stalled output, and
// gives one result per convert word: the 256-entry palette is read through
// its registered read port while the texel sits in the input register, then
// the bit wiring goes into the output register. Palette write words update
// one entry and produce no result; a P8 texel may follow the write of its
// entry in the very next cycle. Palette entries hold nothing defined until
// written, and there is no clearing pass after reset. Unknown format codes
// give color zero with format_known_o low.
// ----------------------------------------------------------------------------
module texel_format_expand_argb8888
  import tfe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [FormatW-1:0]   format_i,
  input  logic [TexelW-1:0]    texel_i,
  input  logic [PalIndexW-1:0] entry_index_i,
  input  logic [ColorW-1:0]    entry_color_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ColorW-1:0]    color_o,
  output logic                 format_known_o
);

  logic               in_acc;
  logic               is_write;
  logic               out_load;
  logic               s1_valid_q;
  logic [FormatW-1:0] s1_format_q;
  logic [TexelW-1:0]  s1_texel_q;
  logic [ColorW-1:0]  pal_rdata;
  logic [ColorW-1:0]  exp_color;
  logic               exp_known;
  logic               out_valid_q;
  logic [ColorW-1:0]  color_q;
  logic               known_q;

  assign is_write   = (kind_e'(kind_i) == KIND_PAL_WRITE);
  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_acc     = in_valid_i && in_ready_o;

  tfe_ram #(
    .Width(ColorW),
    .Depth(PalDepth)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (in_acc && is_write),
    .waddr_i(entry_index_i),
    .wdata_i(entry_color_i),
    .re_i   (in_acc && !is_write),
    .raddr_i(texel_i[PalIndexW-1:0]),
    .rdata_o(pal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_acc && !is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !is_write) begin
      s1_format_q <= format_i;
      s1_texel_q  <= texel_i;
    end
  end

  tfe_expand u_expand (
    .format_i  (s1_format_q),
    .texel_i   (s1_texel_q),
    .pal_data_i(pal_rdata),
    .color_o   (exp_color),
    .known_o   (exp_known)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      color_q <= exp_color;
      known_q <= exp_known;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign color_o        = color_q;
  assign format_known_o = known_q;

`ifndef SYNTHESIS
  a_convert_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !is_write |=> s1_valid_q)
    else $error("convert word did not enter the input stage");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_write |=> !s1_valid_q)
    else $error("palette write occupied the input stage");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q && $stable(s1_texel_q)
      && $stable(pal_rdata))
    else $error("input stage lost its word during a stall");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !format_known_o |-> color_o == '0)
    else $error("unknown format gave a nonzero color");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the texel format expander. A short table of
// directed words (field extremes, every format, unknown codes, palette writes
// with reads right behind them) runs first, then random words with random
// idling on both channels. Convert words are checked against a table color
// or an in-bench expansion of the texel and a shadow copy of the palette.
// ----------------------------------------------------------------------------
module tb_top;
  import tfe_pkg::*;

  localparam int unsigned RandWords   = 1850;
  localparam int unsigned IdlePct     = 37;
  localparam int unsigned WritePct    = 15;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxPrinted  = 50;
  localparam int unsigned QuietFirst  = 700;
  localparam int unsigned QuietLast   = 1000;
  localparam int unsigned HoldAt      = 1200;

  localparam logic [FormatW-1:0] FmtUnused4  = 5'd4;
  localparam logic [FormatW-1:0] FmtUnused31 = 5'd31;

  localparam fmt_e KnownFmts [10] = '{FMT_A8, FMT_Y8, FMT_AY8, FMT_A8Y8, FMT_R5G6B5,
                                      FMT_A1R5G5B5, FMT_A4R4G4B4, FMT_X8R8G8B8,
                                      FMT_A8R8G8B8, FMT_P8};

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic              known;
  } argb_t;

  typedef struct {
    kind_e                kind;
    logic [FormatW-1:0]   fmt;
    logic [TexelW-1:0]    texel;
    logic [PalIndexW-1:0] idx;
    logic [ColorW-1:0]    entry;
    bit                   typed;
    argb_t                want;
  } texel_word_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic                 kind_i         = 1'b0;
  logic [FormatW-1:0]   format_i       = '0;
  logic [TexelW-1:0]    texel_i        = '0;
  logic [PalIndexW-1:0] entry_index_i  = '0;
  logic [ColorW-1:0]    entry_color_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [ColorW-1:0]    color_o;
  logic                 format_known_o;

  bit                   tx_idle_en = 1'b0;
  bit                   rx_idle_en = 1'b0;
  int unsigned          mismatch_cnt = 0;
  int unsigned          cycle_cnt = 0;
  int unsigned          color_cnt = 0;

  logic [ColorW-1:0]    pal_shadow [PalDepth];
  bit                   pal_written [PalDepth];
  logic [PalIndexW-1:0] written_idx [$];
  argb_t                pending_colors [$];
  texel_word_t          dir_rows [$];

  texel_format_expand_argb8888 i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .format_i       (format_i),
    .texel_i        (texel_i),
    .entry_index_i  (entry_index_i),
    .entry_color_i  (entry_color_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .color_o        (color_o),
    .format_known_o (format_known_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic argb_t expand_texel(input logic [FormatW-1:0] f,
                                         input logic [TexelW-1:0] t);
    logic [7:0]  b;
    logic [15:0] p;
    argb_t       r;
    b = t[7:0];
    p = t[15:0];
    r.known = 1'b1;
    case (f)
      FMT_A8:       r.color = {b, 24'h0};
      FMT_Y8:       r.color = {8'hFF, b, b, b};
      FMT_AY8:      r.color = {b, b, b, b};
      FMT_A8Y8:     r.color = {p[15:8], b, b, b};
      FMT_R5G6B5:   r.color = {8'hFF, p[15:11], p[15:13], p[10:5], p[10:9],
                               p[4:0], p[4:2]};
      FMT_A1R5G5B5: r.color = {{8{p[15]}}, p[14:10], p[14:12], p[9:5], p[9:7],
                               p[4:0], p[4:2]};
      FMT_A4R4G4B4: r.color = {p[15:12], p[15:12], p[11:8], p[11:8],
                               p[7:4], p[7:4], p[3:0], p[3:0]};
      FMT_X8R8G8B8,
      FMT_A8R8G8B8: r.color = t;
      FMT_P8:       r.color = pal_shadow[b];
      default: begin
        r.color = '0;
        r.known = 1'b0;
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < MaxPrinted) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic void add_row(input kind_e k, input logic [FormatW-1:0] f,
                                  input logic [TexelW-1:0] t,
                                  input logic [PalIndexW-1:0] i,
                                  input logic [ColorW-1:0] e, input bit typed,
                                  input logic [ColorW-1:0] c, input logic kn);
    texel_word_t w;
    w.kind  = k;
    w.fmt   = f;
    w.texel = t;
    w.idx   = i;
    w.entry = e;
    w.typed = typed;
    w.want  = '{color: c, known: kn};
    dir_rows.push_back(w);
  endfunction

  function automatic texel_word_t random_word();
    texel_word_t w;
    w.kind  = ($urandom_range(99) < WritePct) ? KIND_PAL_WRITE : KIND_CONVERT;
    w.fmt   = ($urandom_range(99) < 80) ? KnownFmts[$urandom_range(9)]
                                        : FormatW'($urandom_range(31));
    case ($urandom_range(9))
      0:       w.texel = '0;
      1:       w.texel = '1;
      default: w.texel = $urandom;
    endcase
    w.idx   = PalIndexW'($urandom_range(PalDepth - 1));
    w.entry = $urandom;
    w.typed = 1'b0;
    w.want  = '0;
    if (w.kind == KIND_CONVERT && w.fmt == FMT_P8)
      w.texel[7:0] = written_idx[$urandom_range(written_idx.size() - 1)];
    return w;
  endfunction

  task automatic send_word(input texel_word_t w);
    while (tx_idle_en && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= w.kind;
    format_i      <= w.fmt;
    texel_i       <= w.texel;
    entry_index_i <= w.idx;
    entry_color_i <= w.entry;
    do @(posedge clk_i); while (!in_ready_o);
    if (w.kind == KIND_PAL_WRITE) begin
      if (!pal_written[w.idx]) written_idx.push_back(w.idx);
      pal_written[w.idx] = 1'b1;
      pal_shadow[w.idx]  = w.entry;
    end else begin
      pending_colors.push_back(w.typed ? w.want : expand_texel(w.fmt, w.texel));
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_colors.size() != 0);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= !(rx_idle_en && $urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin : p_check
    argb_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_colors.size() == 0) begin
        flag_mismatch($sformatf("unexpected word color=%h known=%b",
                                color_o, format_known_o));
      end else begin
        want = pending_colors.pop_front();
        if (color_o !== want.color)
          flag_mismatch($sformatf("word %0d color %h, want %h",
                                  color_cnt, color_o, want.color));
        if (format_known_o !== want.known)
          flag_mismatch($sformatf("word %0d format_known %b, want %b",
                                  color_cnt, format_known_o, want.known));
      end
      color_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_cnt,
               pending_colors.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    foreach (pal_shadow[i]) pal_shadow[i] = '0;
    foreach (pal_written[i]) pal_written[i] = 1'b0;

    //      kind            format        texel          index  entry        typed color
    add_row(KIND_PAL_WRITE, FmtUnused31,  32'hFFFF_FFFF, 8'h00, 32'h1234_5678, 0, '0, 0);
    add_row(KIND_PAL_WRITE, FMT_P8,       32'h0000_0000, 8'hFF, 32'hFFFF_FFFF, 0, '0, 0);
    add_row(KIND_CONVERT,   FMT_P8,       32'hFFFF_FF00, 8'hFF, 32'hFFFF_FFFF,
            1, 32'h1234_5678, 1);
    add_row(KIND_CONVERT,   FMT_P8,       32'h0000_00FF, 8'h00, 32'h0000_0000,
            1, 32'hFFFF_FFFF, 1);
    add_row(KIND_CONVERT,   FMT_A8,       32'hFFFF_FFFF, 8'h5A, 32'hA5A5_A5A5,
            1, 32'hFF00_0000, 1);
    add_row(KIND_CONVERT,   FMT_A8,       32'h0000_0000, 8'h00, 32'h0000_0000,
            1, 32'h0000_0000, 1);
    add_row(KIND_CONVERT,   FMT_Y8,       32'h0000_00AB, 8'h00, 32'h0000_0000,
            1, 32'hFFAB_ABAB, 1);
    add_row(KIND_CONVERT,   FMT_AY8,      32'hFFFF_FF3C, 8'h00, 32'h0000_0000,
            1, 32'h3C3C_3C3C, 1);
    add_row(KIND_CONVERT,   FMT_A8Y8,     32'hFFFF_12FE, 8'h00, 32'h0000_0000,
            1, 32'h12FE_FEFE, 1);
    add_row(KIND_CONVERT,   FMT_R5G6B5,   32'h0000_FFFF, 8'h00, 32'h0000_0000,
            1, 32'hFFFF_FFFF, 1);
    add_row(KIND_CONVERT,   FMT_R5G6B5,   32'hFFFF_0000, 8'h00, 32'h0000_0000,
            1, 32'hFF00_0000, 1);
    add_row(KIND_CONVERT,   FMT_R5G6B5,   32'h0000_1234, 8'h00, 32'h0000_0000, 0, '0, 0);
    add_row(KIND_CONVERT,   FMT_A1R5G5B5, 32'h0000_8000, 8'h00, 32'h0000_0000,
            1, 32'hFF00_0000, 1);
    add_row(KIND_CONVERT,   FMT_A1R5G5B5, 32'hFFFF_7FFF, 8'h00, 32'h0000_0000,
            1, 32'h00FF_FFFF, 1);
    add_row(KIND_CONVERT,   FMT_A1R5G5B5, 32'h0000_ABCD, 8'h00, 32'h0000_0000, 0, '0, 0);
    add_row(KIND_CONVERT,   FMT_A4R4G4B4, 32'h0000_FFFF, 8'h00, 32'h0000_0000,
            1, 32'hFFFF_FFFF, 1);
    add_row(KIND_CONVERT,   FMT_A4R4G4B4, 32'hFFFF_1234, 8'h00, 32'h0000_0000,
            1, 32'h1122_3344, 1);
    add_row(KIND_CONVERT,   FMT_X8R8G8B8, 32'hDEAD_BEEF, 8'h00, 32'h0000_0000,
            1, 32'hDEAD_BEEF, 1);
    add_row(KIND_CONVERT,   FMT_A8R8G8B8, 32'h0000_0000, 8'hFF, 32'hFFFF_FFFF,
            1, 32'h0000_0000, 1);
    add_row(KIND_CONVERT,   FmtUnused31,  32'hFFFF_FFFF, 8'h00, 32'h0000_0000,
            1, 32'h0000_0000, 0);
    add_row(KIND_CONVERT,   FmtUnused4,   32'h1234_5678, 8'h00, 32'h0000_0000,
            1, 32'h0000_0000, 0);
    add_row(KIND_PAL_WRITE, FMT_A8,       32'h0000_005A, 8'h5A, 32'h80FF_00FF, 0, '0, 0);
    add_row(KIND_CONVERT,   FMT_P8,       32'h0000_005A, 8'h00, 32'h0000_0000,
            1, 32'h80FF_00FF, 1);
    add_row(KIND_PAL_WRITE, FMT_P8,       32'h0000_0000, 8'h00, 32'hCAFE_F00D, 0, '0, 0);
    add_row(KIND_CONVERT,   FMT_P8,       32'h8000_0000, 8'h00, 32'h0000_0000, 0, '0, 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rx_idle_en = 1'b1;
    foreach (dir_rows[i]) send_word(dir_rows[i]);
    wait_for_results();

    for (int n = 0; n < RandWords; n++) begin
      tx_idle_en = !(n >= QuietFirst && n < QuietLast);
      rx_idle_en = tx_idle_en;
      if (n == HoldAt) wait_for_results();
      send_word(random_word());
    end
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);

    if (pending_colors.size() != 0)
      flag_mismatch($sformatf("%0d words never arrived", pending_colors.size()));
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
